// ----- rtl/cfsm_pkg.sv -----
package cfsm_pkg;

    // Field widths fixed by the interface.
    localparam int CharW    = 16;
    localparam int PosW     = 16;
    localparam int LenW     = 5;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 64;
    localparam int PatWords = 4;

    // Longest pattern supported; the window never holds more than 16 characters.
    localparam int PatternMax = 16;
    localparam int WinDepth   = (PatternMax < 16) ? PatternMax : 16;
    localparam int FillW      = $clog2(WinDepth + 1);

    // Code ranges that case folding moves up by FoldOffset.
    localparam logic [CharW-1:0] FoldLoA    = 16'd65;
    localparam logic [CharW-1:0] FoldHiA    = 16'd90;
    localparam logic [CharW-1:0] FoldLoB    = 16'd192;
    localparam logic [CharW-1:0] FoldHiB    = 16'd294;
    localparam logic [CharW-1:0] FoldOffset = 16'd32;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        RegPatWord0 = 3'd0,
        RegPatWord1 = 3'd1,
        RegPatWord2 = 3'd2,
        RegPatWord3 = 3'd3,
        RegPatLen   = 3'd4,
        RegCaseFold = 3'd5,
        RegBackward = 3'd6
    } t_cfg_reg;

    // Pattern as the comparators see it, already folded and aligned.
    typedef struct packed {
        logic [WinDepth-1:0][CharW-1:0] pat_fwd;
        logic [WinDepth-1:0][CharW-1:0] pat_bwd;
        logic [LenW-1:0]                eff_len;
        logic                           fold;
        logic                           backward;
    } t_cfg;

    // One text character request.
    typedef struct packed {
        logic [CharW-1:0] text_char;
        logic [PosW-1:0]  char_position;
        logic             start_of_text;
        logic             last_char;
    } t_item;

    // One result request.
    typedef struct packed {
        logic            valid;
        logic            match_found;
        logic [PosW-1:0] match_position;
    } t_result;

    // Case folding of a single character code.
    function automatic logic [CharW-1:0] fold_char(input logic [CharW-1:0] c,
                                                   input logic en);
        logic in_range;
        in_range = ((c >= FoldLoA) && (c <= FoldHiA)) || ((c >= FoldLoB) && (c <= FoldHiB));
        return (en && in_range) ? (c + FoldOffset) : c;
    endfunction

endpackage

// ----- rtl/cfsm_cfg.sv -----
module cfsm_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  logic [cfsm_pkg::CfgIdxW-1:0] i_index,
    input  logic [cfsm_pkg::CfgDataW-1:0] i_data,
    output cfsm_pkg::t_cfg               o_cfg
);
    import cfsm_pkg::*;

    logic [PatWords-1:0][CfgDataW-1:0] r_pat;
    logic [LenW-1:0]                   r_len;
    logic                              r_fold;
    logic                              r_bwd;

    logic [PatWords*CfgDataW-1:0]      pat_flat;
    logic [WinDepth*CharW-1:0]         pat_rev;
    logic [WinDepth*CharW-1:0]         pat_shift;
    logic [LenW-1:0]                   eff_len;

    // Register writes; an index past the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_len  <= LenW'(1);
            r_fold <= 1'b1;
            r_bwd  <= 1'b0;
        end else if (i_wr) begin
            unique case (t_cfg_reg'(i_index))
                RegPatWord0, RegPatWord1, RegPatWord2, RegPatWord3: begin
                    r_pat[i_index[1:0]] <= i_data;
                end
                RegPatLen:   r_len  <= i_data[LenW-1:0];
                RegCaseFold: r_fold <= i_data[0];
                RegBackward: r_bwd  <= i_data[0];
                default: ;
            endcase
        end
    end

    // A length of zero acts as one, anything past the window as the window depth.
    always_comb begin
        if (r_len == '0) begin
            eff_len = LenW'(1);
        end else if (r_len > LenW'(WinDepth)) begin
            eff_len = LenW'(WinDepth);
        end else begin
            eff_len = r_len;
        end
    end

    // Reverse the pattern and shift it so that window entry k meets
    // pattern character eff_len-1-k in forward mode.
    assign pat_flat = r_pat;

    always_comb begin
        for (int j = 0; j < WinDepth; j++) begin
            pat_rev[j*CharW +: CharW] = pat_flat[(WinDepth-1-j)*CharW +: CharW];
        end
    end

    assign pat_shift = pat_rev >> (CharW * (LenW'(WinDepth) - eff_len));

    // Fold the pattern side once, here, for both directions.
    always_comb begin
        for (int k = 0; k < WinDepth; k++) begin
            o_cfg.pat_fwd[k] = fold_char(pat_shift[k*CharW +: CharW], r_fold);
            o_cfg.pat_bwd[k] = fold_char(pat_flat[k*CharW +: CharW], r_fold);
        end
        o_cfg.eff_len  = eff_len;
        o_cfg.fold     = r_fold;
        o_cfg.backward = r_bwd;
    end

endmodule

// ----- rtl/cfsm_match.sv -----
module cfsm_match (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfsm_pkg::t_cfg    i_cfg,
    input  logic              i_step,
    input  cfsm_pkg::t_item   i_item,
    output cfsm_pkg::t_result o_res
);
    import cfsm_pkg::*;

    logic [WinDepth-1:0][CharW-1:0] r_win;
    logic [FillW-1:0]               r_fill;
    logic                           r_done;

    logic [WinDepth-1:0][CharW-1:0] n_win;
    logic [FillW-1:0]               n_fill;
    logic                           done_eff;
    logic [WinDepth-1:0]            char_ok;
    logic                           hit;

    // Window after this character; start of text drops the old contents.
    always_comb begin
        n_win[0] = i_item.text_char;
        for (int k = 1; k < WinDepth; k++) begin
            n_win[k] = i_item.start_of_text ? '0 : r_win[k-1];
        end
    end

    always_comb begin
        if (i_item.start_of_text) begin
            n_fill = FillW'(1);
        end else if (r_fill < FillW'(WinDepth)) begin
            n_fill = r_fill + FillW'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    assign done_eff = i_item.start_of_text ? 1'b0 : r_done;

    // One comparator per window entry; entries past the length always pass.
    always_comb begin
        for (int k = 0; k < WinDepth; k++) begin
            char_ok[k] = (LenW'(k) >= i_cfg.eff_len) ||
                         (fold_char(n_win[k], i_cfg.fold) ==
                          (i_cfg.backward ? i_cfg.pat_bwd[k] : i_cfg.pat_fwd[k]));
        end
    end

    assign hit = (&char_ok) && (LenW'(n_fill) >= i_cfg.eff_len);

    // One result per text: the first match, or not-found on the last character.
    always_comb begin
        o_res.valid          = !done_eff && (hit || i_item.last_char);
        o_res.match_found    = hit;
        o_res.match_position = '0;
        if (hit) begin
            o_res.match_position = i_cfg.backward ? i_item.char_position :
                i_item.char_position - PosW'(i_cfg.eff_len - LenW'(1));
        end
    end

    // Window contents are only compared once filled, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_done <= 1'b0;
        end else if (i_step) begin
            r_fill <= n_fill;
            r_done <= done_eff || o_res.valid;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FillW'(WinDepth))
        else $error("window fill count beyond window depth");

    a_silent_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_done && !i_item.start_of_text |-> !o_res.valid)
        else $error("second result within one text");

    a_done_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.valid |=> r_done)
        else $error("result given without marking the text done");

endmodule

// ----- rtl/case_folding_substring_matcher.sv -----
// Case-folding substring matcher.
// Text characters enter on the s_axis channel, one request per character:
// tdata carries the character code and its 1-based position, tuser marks the
// start of a text and tlast its final character. The pattern, its length,
// case folding and search direction are set on the cfg channel, which is
// always ready and must only be written while no text is in flight.
// Each text yields exactly one request on the m_axis channel: tuser high with
// the match start in tdata at the first match, or tuser low and tdata zero
// on the last character when no match was seen. Characters after a result
// are absorbed silently until the next start of text.
// A character is held in the input register after acceptance; its result is
// loaded into the output register when it advances and is taken from there.
// Throughput is one character per cycle; the sixteen window comparators and
// the output register sustain that rate while the output is taken each cycle.
// When the receiver stalls, the result is held in the output register and one
// further character waits in the input register before tready drops.
// Reset clears the window fill, the per-text state, the valid flags of both
// pipeline registers and the configuration (length 1, folding on, forward search).
module case_folding_substring_matcher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cfsm_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [cfsm_pkg::CfgDataW-1:0]     i_cfg_data,
    // Text input; tdata: text_char [15:0], char_position [31:16].
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [cfsm_pkg::CharW+cfsm_pkg::PosW-1:0] i_s_axis_tdata,
    input  logic                              i_s_axis_tuser,   // start_of_text
    input  logic                              i_s_axis_tlast,   // last_char
    // Results; tdata: match_position [15:0].
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [cfsm_pkg::PosW-1:0]         o_m_axis_tdata,
    output logic                              o_m_axis_tuser    // match_found
);
    import cfsm_pkg::*;

    t_cfg            cfg;
    t_result         res;
    t_item           r_in;
    logic            r_in_valid;
    logic            r_out_valid;
    logic            r_out_found;
    logic [PosW-1:0] r_out_pos;
    logic            in_accept;
    logic            advance;

    assign o_cfg_ready = 1'b1;

    cfsm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // The held character moves on whenever the output register is free or draining.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.text_char     <= i_s_axis_tdata[CharW-1:0];
            r_in.char_position <= i_s_axis_tdata[CharW +: PosW];
            r_in.start_of_text <= i_s_axis_tuser;
            r_in.last_char     <= i_s_axis_tlast;
        end
    end

    cfsm_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (advance),
        .i_item  (r_in),
        .o_res   (res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res.valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_out_found <= res.match_found;
            r_out_pos   <= res.match_position;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_pos;
    assign o_m_axis_tuser  = r_out_found;

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("not-found result with nonzero position");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_m_axis_tready |=> r_in_valid && $stable(r_in))
        else $error("held character lost during output stall");

endmodule
